// File: rtl/core/aac_pkg.sv
// Package for the annealing acceptance controller: request and result types,
// register map codes, and the exp(-x) probability table. No dependencies.
`default_nettype none
package aac_pkg;

	localparam int PROB_SCALE = 1000;
	localparam int EXP_TABLE_DEPTH = 256;
	localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
	localparam int PROB_W = $clog2(PROB_SCALE + 1);

	localparam logic [2:0] REG_T_START = 3'd0;
	localparam logic [2:0] REG_T_END = 3'd1;
	localparam logic [2:0] REG_COOLING = 3'd2;
	localparam logic [2:0] REG_MOVES = 3'd3;
	localparam logic [2:0] REG_MAXIMIZE = 3'd4;

	localparam logic OP_START = 1'b0;
	localparam logic OP_CAND = 1'b1;

	typedef struct packed {
		logic        op;
		logic [30:0] score;
		logic [9:0]  random_draw;
	} req_t;

	typedef struct packed {
		logic        accepted;
		logic        new_best;
		logic        run_finished;
		logic [31:0] temperature;
		logic [30:0] current_score;
		logic [30:0] best_score;
		logic        best_valid;
	} res_t;

	typedef struct packed {
		logic [31:0] t_start;
		logic [31:0] t_end;
		logic [15:0] cooling_rate;
		logic [15:0] moves;
		logic        maximize;
	} cfg_t;

	typedef logic [PROB_W-1:0] prob_t;
	typedef prob_t prob_tab_t [EXP_TABLE_DEPTH];

	function automatic logic [63:0] exp_neg_step(input logic [63:0] h);
		logic [63:0] term, pos, neg;
		term = 64'd1 << 30;
		pos = 64'd1 << 30;
		neg = 64'd0;
		for (int k = 1; k <= 24; k++) begin
			term = ((term * h) >> 30) / 64'(k);
			if (k % 2 == 1) neg = neg + term;
			else pos = pos + term;
		end
		return (pos > neg) ? pos - neg : 64'd0;
	endfunction

	function automatic prob_tab_t build_prob();
		prob_tab_t t;
		logic [63:0] h, r, v;
		h = (64'd16 << 30) / 64'(EXP_TABLE_DEPTH);
		r = exp_neg_step(h);
		v = 64'd1 << 30;
		for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
			if (i > 0) v = (v * r + (64'd1 << 29)) >> 30;
			t[i] = PROB_W'((64'(PROB_SCALE) * v) >> 30);
		end
		return t;
	endfunction

	localparam prob_tab_t PROB_TAB = build_prob();

endpackage
`default_nettype wire

// File: rtl/core/annealing_acceptance_controller_unit.sv
// Top level of the annealing acceptance controller: APB register file,
// sequencer and state. Uses aac_pkg, aac_divider and aac_cooler.
//
// Usage: program registers over APB (t_start 0x00, t_end 0x04, cooling_rate
// 0x08, moves_per_temperature 0x0C, maximize 0x10) while idle. Requests come in
// on the req channel (valid/ready) and each yields one result on the res channel.
// A start request, or a candidate while the run is finished, goes from idle
// straight to the output state. A candidate that is better, equal, or met at
// zero temperature passes the divide, judge and output states without the
// divider. Any other candidate runs the bit-serial divider for d/T and a table
// lookup; cooling adds a pass through the shift-add multiplier. ready is high
// whenever the sequencer is idle, so the next request can be taken as soon as
// a result is presented. A stalled receiver holds the result in the output
// register while one more request is worked; that request waits at the end
// until the register frees. Reset clears state and loads register reset values;
// the run is finished until a start request with t_start >= t_end arrives.
`default_nettype none
module annealing_acceptance_controller_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           psel,
	input  wire logic           penable,
	input  wire logic           pwrite,
	input  wire logic [4:0]     paddr,
	input  wire logic [31:0]    pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire aac_pkg::req_t  req,
	output logic                res_valid,
	input  wire logic           res_ready,
	output aac_pkg::res_t       res
);
	import aac_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV = 3'd1;
	localparam logic [2:0] ST_JUDGE = 3'd2;
	localparam logic [2:0] ST_COOL = 3'd3;
	localparam logic [2:0] ST_OUT = 3'd4;

	cfg_t cfg_q;
	logic [2:0]  state_q;
	req_t        req_q;
	logic [30:0] held_q, best_q;
	logic        best_v_q, fin_q, acc_q, nb_q, prob_ok_q, div_go_q;
	logic [31:0] temp_q;
	logic [15:0] move_q;

	logic        div_start, div_done, div_big, cool_start, cool_done;
	logic [19:0] div_quot;
	logic [31:0] cool_out;
	logic [30:0] diff;
	logic        better, beats_best, out_load;
	logic [15:0] move_nx;
	logic [2:0]  widx;

	assign pready = 1'b1;
	assign widx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{t_start: 32'd6553600, t_end: 32'd65536, cooling_rate: 16'd62259,
				moves: 16'd100, maximize: 1'b0};
		end else if (psel && penable && pwrite) begin
			unique case (widx)
				REG_T_START:  cfg_q.t_start <= pwdata;
				REG_T_END:    cfg_q.t_end <= pwdata;
				REG_COOLING:  cfg_q.cooling_rate <= pwdata[15:0];
				REG_MOVES:    cfg_q.moves <= pwdata[15:0];
				REG_MAXIMIZE: cfg_q.maximize <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (widx)
			REG_T_START:  prdata = cfg_q.t_start;
			REG_T_END:    prdata = cfg_q.t_end;
			REG_COOLING:  prdata = {16'd0, cfg_q.cooling_rate};
			REG_MOVES:    prdata = {16'd0, cfg_q.moves};
			REG_MAXIMIZE: prdata = {31'd0, cfg_q.maximize};
			default:      prdata = 32'd0;
		endcase
	end

	assign diff = (req_q.score > held_q) ? req_q.score - held_q : held_q - req_q.score;
	assign better = cfg_q.maximize ? (req_q.score > held_q) : (req_q.score < held_q);
	assign beats_best = cfg_q.maximize ? (req_q.score > best_q) : (req_q.score < best_q);
	assign move_nx = move_q + 16'd1;

	assign req_ready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_OUT) && (!res_valid || res_ready);
	assign div_start = div_go_q && !better && (diff != 31'd0) && (temp_q != 32'd0);
	assign cool_start = (state_q == ST_JUDGE) && (move_nx >= cfg_q.moves);

	aac_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(diff),
		.divisor(temp_q), .done(div_done), .quot(div_quot), .big(div_big)
	);

	aac_cooler u_cool (
		.clk(clk), .arst_n(arst_n), .start(cool_start), .temp_in(temp_q),
		.rate(cfg_q.cooling_rate), .done(cool_done), .temp_out(cool_out)
	);

	logic [IDX_W-1:0] tab_idx;
	logic             x_over;
	assign x_over = div_big;
	assign tab_idx = IDX_W'(({12'd0, div_quot} * 32'(EXP_TABLE_DEPTH)) >> 20);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_valid <= 1'b0;
			held_q <= '0;
			best_q <= '0;
			best_v_q <= 1'b0;
			fin_q <= 1'b1;
			temp_q <= '0;
			move_q <= '0;
			acc_q <= 1'b0;
			nb_q <= 1'b0;
			prob_ok_q <= 1'b0;
			div_go_q <= 1'b0;
		end else begin
			res_valid <= out_load || (res_valid && !res_ready);
			div_go_q <= (state_q == ST_IDLE) && req_valid && (req.op == OP_CAND) && !fin_q;
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid && req_ready) begin
						req_q <= req;
						acc_q <= 1'b0;
						nb_q <= 1'b0;
						if (req.op == OP_START) begin
							held_q <= req.score;
							best_q <= '0;
							best_v_q <= 1'b0;
							temp_q <= cfg_q.t_start;
							move_q <= '0;
							fin_q <= cfg_q.t_start < cfg_q.t_end;
							state_q <= ST_OUT;
						end else if (fin_q) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (better) begin
						prob_ok_q <= 1'b0;
						state_q <= ST_JUDGE;
					end else if (diff == 31'd0) begin
						prob_ok_q <= 32'(req_q.random_draw) < 32'(PROB_SCALE);
						state_q <= ST_JUDGE;
					end else if (temp_q == 32'd0) begin
						prob_ok_q <= 1'b0;
						state_q <= ST_JUDGE;
					end else if (div_done) begin
						prob_ok_q <= !x_over &&
							(32'(req_q.random_draw) < 32'(PROB_TAB[tab_idx]));
						state_q <= ST_JUDGE;
					end
				end
				ST_JUDGE: begin
					if (better || prob_ok_q) begin
						acc_q <= 1'b1;
						held_q <= req_q.score;
						if (!best_v_q || beats_best) begin
							best_q <= req_q.score;
							best_v_q <= 1'b1;
							nb_q <= 1'b1;
						end
					end
					if (move_nx >= cfg_q.moves) begin
						move_q <= '0;
						state_q <= ST_COOL;
					end else begin
						move_q <= move_nx;
						state_q <= ST_OUT;
					end
				end
				ST_COOL: begin
					if (cool_done) begin
						temp_q <= cool_out;
						if (cool_out < cfg_q.t_end) fin_q <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res.accepted <= acc_q;
			res.new_best <= nb_q;
			res.run_finished <= fin_q;
			res.temperature <= temp_q;
			res.current_score <= held_q;
			res.best_score <= best_q;
			res.best_valid <= best_v_q;
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/aac_divider.sv
// Restoring divider, one quotient bit per cycle: q = floor((d << 32) / t).
// Only the low 20 quotient bits and an overflow flag are kept. Uses aac_pkg.
`default_nettype none
module aac_divider (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [30:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [19:0]      quot,
	output logic             big
);
	import aac_pkg::*;

	logic [62:0] num_q;
	logic [32:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [33:0] trial;

	assign trial = {rem_q, num_q[62]} - {2'b00, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd62) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {dividend, 32'd0};
			rem_q <= '0;
			quot <= '0;
			big <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[61:0], 1'b0};
			if (!trial[33]) begin
				rem_q <= trial[32:0];
				if (cnt_q < 6'd43) big <= 1'b1;
				quot <= {quot[18:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], num_q[62]};
				quot <= {quot[18:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/aac_cooler.sv
// Shift-add multiplier for cooling: t = (t * rate) >> 16, one rate bit a cycle.
// Uses aac_pkg.
`default_nettype none
module aac_cooler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] temp_in,
	input  wire logic [15:0] rate,
	output logic             done,
	output logic [31:0]      temp_out
);
	import aac_pkg::*;

	logic [47:0] acc_q;
	logic [15:0] rate_q;
	logic [31:0] t_q;
	logic [4:0]  cnt_q;
	logic        busy_q;

	assign temp_out = acc_q[47:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd15) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			rate_q <= rate;
			t_q <= temp_in;
		end else if (busy_q) begin
			acc_q <= {1'b0, acc_q[47:1]} + (rate_q[0] ? {1'b0, t_q, 15'd0} : 48'd0);
			rate_q <= {1'b0, rate_q[15:1]};
		end
	end
endmodule
`default_nettype wire
